/* design/pixel_format_to_argb32_defines.svh */
// ----------------------------------------------------------------------------
// pixel_format_to_argb32 assertion macros
// shared property forms for the checker of the pixel converter
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_TO_ARGB32_DEFINES_SVH
`define PIXEL_FORMAT_TO_ARGB32_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_format_to_argb32: same-cycle property failed");

// next-cycle implication, disabled during reset
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_format_to_argb32: next-cycle property failed");

`endif

/* design/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// types, constants and scaling tables of the pixel format converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfa_pkg;

  // palette geometry
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int unsigned PAL_W       = 24;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_RED_SWAPPED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP_WORDS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE      = 2'd3;
  localparam int unsigned CFG_DATA_W = 3;

  // command codes
  localparam logic CMD_CONVERT   = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  typedef enum logic [2:0] {
    FMT_PALETTE   = 3'd0,
    FMT_RGB555    = 3'd1,
    FMT_RGB565    = 3'd2,
    FMT_PACKED24  = 3'd3,
    FMT_RGB24IN32 = 3'd4,
    FMT_RGB101010 = 3'd5,
    FMT_ARGB32    = 3'd6
  } pfa_fmt_e;

  typedef struct packed {
    pfa_fmt_e fmt;
    logic     bgr;
    logic     byte_swap;
    logic     mask_en;
  } pfa_cfg_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // floor(255 * v / 31)
  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // floor(255 * v / 63)
  localparam logic [7:0] SCALE6 [64] = '{
    8'd0,   8'd4,   8'd8,   8'd12,  8'd16,  8'd20,  8'd24,  8'd28,
    8'd32,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd56,  8'd60,
    8'd64,  8'd68,  8'd72,  8'd76,  8'd80,  8'd85,  8'd89,  8'd93,
    8'd97,  8'd101, 8'd105, 8'd109, 8'd113, 8'd117, 8'd121, 8'd125,
    8'd129, 8'd133, 8'd137, 8'd141, 8'd145, 8'd149, 8'd153, 8'd157,
    8'd161, 8'd165, 8'd170, 8'd174, 8'd178, 8'd182, 8'd186, 8'd190,
    8'd194, 8'd198, 8'd202, 8'd206, 8'd210, 8'd214, 8'd218, 8'd222,
    8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd246, 8'd250, 8'd255
  };

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    swap16 = {v[7:0], v[15:8]};
  endfunction

endpackage

/* design/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pfa_convert.sv */
// ----------------------------------------------------------------------------
// pfa_convert
// combinational conversion of one registered source word to argb
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfa_convert import pfa_pkg::*; (
  input  pfa_cfg_t          cfg_i,
  input  logic [31:0]       raw_i,
  input  logic              mask_bit_i,
  input  logic              pal_hit_i,
  input  logic [PAL_W-1:0]  pal_rgb_i,
  output logic [31:0]       argb_o
);

  logic [15:0] p16;
  logic [31:0] p32;
  logic [7:0]  alpha;
  logic [23:0] rgb;

  always_comb begin
    p16   = cfg_i.byte_swap ? swap16(raw_i[15:0]) : raw_i[15:0];
    p32   = cfg_i.byte_swap ? swap32(raw_i) : raw_i;
    alpha = (cfg_i.mask_en && !mask_bit_i) ? 8'h00 : ALPHA_OPAQUE;
    rgb   = '0;
    argb_o = '0;
    case (cfg_i.fmt)
      FMT_PALETTE: begin
        rgb    = pal_hit_i ? pal_rgb_i : '0;
        argb_o = {alpha, rgb};
      end
      FMT_RGB555: begin
        rgb    = {SCALE5[p16[14:10]], SCALE5[p16[9:5]], SCALE5[p16[4:0]]};
        argb_o = {alpha, rgb};
      end
      FMT_RGB565: begin
        rgb    = {SCALE5[p16[15:11]], SCALE6[p16[10:5]], SCALE5[p16[4:0]]};
        argb_o = {alpha, rgb};
      end
      FMT_PACKED24, FMT_RGB24IN32: begin
        rgb    = cfg_i.bgr ? {p32[7:0], p32[15:8], p32[23:16]} : p32[23:0];
        argb_o = {alpha, rgb};
      end
      FMT_RGB101010: begin
        // keep the top 8 bits of each 10-bit channel
        rgb    = cfg_i.bgr ? {p32[9:2], p32[19:12], p32[29:22]}
                           : {p32[29:22], p32[19:12], p32[9:2]};
        argb_o = {alpha, rgb};
      end
      FMT_ARGB32: begin
        argb_o = cfg_i.bgr ? swap32(p32) : p32;
        if (cfg_i.mask_en && !mask_bit_i) begin
          argb_o[31:24] = 8'h00;
        end
      end
      default: begin
        argb_o = '0;
      end
    endcase
  end

endmodule

/* design/pixel_format_to_argb32.sv */
// ----------------------------------------------------------------------------
// pixel_format_to_argb32
// converts one raw display pixel per clock, while the output does not stall, into a 32-bit argb word
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock while the output does not stall; a
// converted pixel passes through the input register and then the result
// register, the input register pairing with the registered read of the palette
// ram, which is looked up in the same edge that takes the pixel. A palette write (cmd 1) updates
// the entry at the accepting edge and gives no output, as does a convert
// while source_format holds the unused code 7. Palette entries hold no reset
// value: only read entries that have been written. Configuration registers
// (index 0 source_format, 1 blue_red_swapped, 2 byte_swap_words,
// 3 mask_enable) may only be written while the block is idle.
`timescale 1ns / 1ps

module pixel_format_to_argb32 import pfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [31:0]           raw_pixel_i,
  input  logic                  mask_bit_i,
  input  logic [7:0]            palette_index_i,
  input  logic [23:0]           palette_rgb_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           argb_o
);

  // configuration registers
  pfa_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt       <= FMT_ARGB32;
      cfg_q.bgr       <= 1'b0;
      cfg_q.byte_swap <= 1'b0;
      cfg_q.mask_en   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SOURCE_FORMAT:    cfg_q.fmt       <= pfa_fmt_e'(cfg_wdata_i[2:0]);
        CFG_BLUE_RED_SWAPPED: cfg_q.bgr       <= cfg_wdata_i[0];
        CFG_BYTE_SWAP_WORDS:  cfg_q.byte_swap <= cfg_wdata_i[0];
        CFG_MASK_ENABLE:      cfg_q.mask_en   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic out_ready;
  logic s1_load;
  logic fmt_known;

  logic        s1_v_q, s1_v_d;
  logic [31:0] s1_raw_q;
  logic        s1_mask_q;
  logic        s1_hit_q;
  logic        out_v_q, out_v_d;
  logic [31:0] argb_q;
  logic [31:0] argb_d;

  // result register frees when empty or when its transaction is taken
  assign out_ready = !out_v_q || !out_stall_i;
  // input register frees when empty or when it moves on
  assign in_stall_o = s1_v_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // unused format code gives no result, so such a pixel never enters
  always_comb begin
    case (cfg_q.fmt)
      FMT_PALETTE, FMT_RGB555, FMT_RGB565, FMT_PACKED24,
      FMT_RGB24IN32, FMT_RGB101010, FMT_ARGB32: fmt_known = 1'b1;
      default:                                  fmt_known = 1'b0;
    endcase
  end

  assign s1_load = in_acc && (cmd_i == CMD_CONVERT) && fmt_known;

  // palette: written and read on the accepting edge
  logic             pal_wr_hit;
  logic             pal_rd_hit;
  logic [PAL_W-1:0] pal_rdata;

  // indexes at or above the store depth are ignored on write, zero on read
  assign pal_wr_hit = {1'b0, palette_index_i} < 9'(PAL_ENTRIES);
  assign pal_rd_hit = {1'b0, raw_pixel_i[7:0]} < 9'(PAL_ENTRIES);

  pfa_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PAL_ENTRIES)
  ) u_pfa_palette (
    .clk_i   (clk_i),
    .we_i    (in_acc && (cmd_i == CMD_PAL_WRITE) && pal_wr_hit),
    .waddr_i (palette_index_i[PAL_AW-1:0]),
    .wdata_i (palette_rgb_i),
    .re_i    (s1_load),
    .raddr_i (raw_pixel_i[PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  // input register
  assign s1_v_d = s1_load || (s1_v_q && !out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_raw_q  <= raw_pixel_i;
      s1_mask_q <= mask_bit_i;
      s1_hit_q  <= pal_rd_hit;
    end
  end

  // conversion between the two registers
  pfa_convert u_pfa_convert (
    .cfg_i      (cfg_q),
    .raw_i      (s1_raw_q),
    .mask_bit_i (s1_mask_q),
    .pal_hit_i  (s1_hit_q),
    .pal_rgb_i  (pal_rdata),
    .argb_o     (argb_d)
  );

  // result register
  assign out_v_d = out_ready ? s1_v_q : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_v_q) begin
      argb_q <= argb_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign argb_o      = argb_q;

endmodule

/* design/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker
// port-level assertions for the pixel format converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pixel_format_to_argb32_defines.svh"

module pfa_checker import pfa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  cmd_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [31:0]           argb_o
);

  logic in_xact;
  logic out_held;

  assign in_xact  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // a held result keeps its word
  `PFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(argb_o))

  // input back-pressure only comes from a stalled result
  `PFA_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_held)

  // a fresh result follows an accepted convert transaction
  `PFA_ASSERT_IMPL(a_out_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_xact && (cmd_i == CMD_CONVERT), 2))

endmodule

bind pixel_format_to_argb32 pfa_checker u_pfa_checker (.*);
